[hdl/binary_blob_header_checker_defines.svh]
// Assertion macros for the blob header checker.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef BINARY_BLOB_HEADER_CHECKER_DEFINES_SVH
`define BINARY_BLOB_HEADER_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBHC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BBHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/bbhc_pkg.sv]
// Shared types and constants for the blob header checker.
// No dependencies; used by the top level.
`timescale 1ns / 1ps

package bbhc_pkg;

	localparam int unsigned ADDR_W    = 4;
	localparam int unsigned REG_IDX_W = 2;
	localparam int unsigned IDX_W     = 5;

	// Register map, indexed by paddr[3:2]
	localparam logic [REG_IDX_W-1:0] REG_TYPE_HASH   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FORMAT_HASH = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CONTAINER   = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_FLAGS       = 2'd3;

	// Header byte offsets
	localparam logic [IDX_W-1:0] IDX_VERSION  = 5'd4;
	localparam logic [IDX_W-1:0] IDX_CHECKSUM = 5'd8;
	localparam logic [IDX_W-1:0] IDX_TYPE     = 5'd12;
	localparam logic [IDX_W-1:0] IDX_FORMAT   = 5'd16;
	localparam logic [IDX_W-1:0] IDX_TAIL     = 5'd20;
	localparam logic [IDX_W-1:0] IDX_LAST     = 5'd23;

	localparam logic [31:0] VERSION_NO_CHECKSUM = 32'd1;
	localparam logic [31:0] MAX_VERSION         = 32'd3;

	// Magic bytes, entry 0 first on the wire
	localparam logic [3:0][7:0] HDR_MAGIC = {8'h4F, 8'h4C, 8'h4F, 8'h56};

	typedef enum logic [2:0] {
		ST_OK                 = 3'd0,
		ST_BAD_MAGIC          = 3'd1,
		ST_TRUNCATED          = 3'd2,
		ST_BAD_VERSION        = 3'd3,
		ST_TYPE_MISMATCH      = 3'd4,
		ST_CONTAINER_MISMATCH = 3'd5,
		ST_FLAGS_MISMATCH     = 3'd6,
		ST_FORMAT_MISMATCH    = 3'd7
	} status_t;

endpackage

[hdl/bbhc_if.sv]
// Valid/ready channel interfaces for the blob header checker.
// Byte input channel and header result channel; depend on nothing else.
`timescale 1ns / 1ps

interface bbhc_byte_if;
	logic       valid;
	logic       ready;
	logic       has_byte;
	logic [7:0] data_byte;
	logic       end_of_input;

	modport source (output valid, has_byte, data_byte, end_of_input, input ready);
	modport sink   (input valid, has_byte, data_byte, end_of_input, output ready);
endinterface

interface bbhc_hdr_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] version;
	logic [31:0] checksum;
	logic [31:0] type_hash;
	logic [31:0] format_hash;
	logic [7:0]  container_code;
	logic [7:0]  flag_bits;
	logic [15:0] fixed_count;

	modport source (output valid, status, version, checksum, type_hash, format_hash,
		container_code, flag_bits, fixed_count, input ready);
	modport sink   (input valid, status, version, checksum, type_hash, format_hash,
		container_code, flag_bits, fixed_count, output ready);
endinterface

[hdl/binary_blob_header_checker.sv]
// Blob header checker.
// byte_in takes one blob byte per beat (or a bare end marker); hdr_out gives one
// result beat per header with a status and the decoded fields.
// Registers are written over the APB port at byte addresses 0, 4, 8 and 12:
// expected type hash, expected format hash, expected container, expected flags.
// A byte beat is caught in an input register and parsed there; the header fields
// are built up in field registers and a result is loaded into the output
// register. The beat that ends a header passes through the input register, and
// its result is registered in the output register, which drives hdr_out; one
// byte beat is taken every cycle while hdr_out is not stalled.
// When hdr_out is stalled the result holds in the output register; the input
// register takes one more beat and holds it, and byte_in drops ready until the
// result is taken. Beats after a result are dropped until the end marker, and
// the next beat starts a new header.
// Reset clears the field registers, the configuration registers and both
// channels; byte_in is ready as soon as reset is released.
// Depends on bbhc_pkg, bbhc_if and binary_blob_header_checker_defines.svh.
`timescale 1ns / 1ps
`include "binary_blob_header_checker_defines.svh"

module binary_blob_header_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bbhc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	bbhc_byte_if.sink                  byte_in,
	bbhc_hdr_if.source                 hdr_out
);
	import bbhc_pkg::*;

	logic [31:0] exp_type_q;
	logic [31:0] exp_format_q;
	logic [7:0]  exp_container_q;
	logic [7:0]  exp_flags_q;

	logic       valid_s1;
	logic       has_byte_s1;
	logic [7:0] data_byte_s1;
	logic       eoi_s1;

	logic [IDX_W-1:0] byte_index_q;
	logic             finished_q;
	logic             magic_ok_q;
	logic [31:0]      version_q;
	logic [31:0]      checksum_q;
	logic [31:0]      type_hash_q;
	logic [31:0]      format_hash_q;
	logic [31:0]      tail_q;

	logic             out_valid_q;
	status_t          res_status_q;
	logic [31:0]      res_version_q;
	logic [31:0]      res_checksum_q;
	logic [31:0]      res_type_q;
	logic [31:0]      res_format_q;
	logic [31:0]      res_tail_q;

	logic             cfg_we;
	logic [REG_IDX_W-1:0] reg_idx;
	logic             s1_go;
	logic             in_acc;
	logic [31:0]      lane_word;

	logic             res_done;
	status_t          res_status;
	logic [IDX_W-1:0] idx_d;
	logic             mok_d;
	logic [31:0]      ver_d;
	logic [31:0]      chk_d;
	logic [31:0]      typ_d;
	logic [31:0]      fmt_d;
	logic [31:0]      tail_d;

	logic [IDX_W-1:0] idx_n;
	logic             fin_n;
	logic             mok_n;
	logic [31:0]      ver_n;
	logic [31:0]      chk_n;
	logic [31:0]      typ_n;
	logic [31:0]      fmt_n;
	logic [31:0]      tail_n;

	// Configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_we  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_type_q      <= '0;
			exp_format_q    <= '0;
			exp_container_q <= '0;
			exp_flags_q     <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx)
				REG_TYPE_HASH:   exp_type_q      <= pwdata;
				REG_FORMAT_HASH: exp_format_q    <= pwdata;
				REG_CONTAINER:   exp_container_q <= pwdata[7:0];
				REG_FLAGS:       exp_flags_q     <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TYPE_HASH:   prdata = exp_type_q;
			REG_FORMAT_HASH: prdata = exp_format_q;
			REG_CONTAINER:   prdata = {24'd0, exp_container_q};
			REG_FLAGS:       prdata = {24'd0, exp_flags_q};
		endcase
	end

	// Handshake: the input register advances when the output slot is free or emptying
	assign s1_go         = valid_s1 & (~out_valid_q | hdr_out.ready);
	assign byte_in.ready = ~valid_s1 | s1_go;
	assign in_acc        = byte_in.valid & byte_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			has_byte_s1  <= byte_in.has_byte;
			data_byte_s1 <= byte_in.data_byte;
			eoi_s1       <= byte_in.end_of_input;
		end
	end

	// Byte lane of the incoming byte within its 32-bit field
	assign lane_word = 32'(data_byte_s1) << {byte_index_q[1:0], 3'b000};

	// Parse one beat
	always_comb begin
		res_done   = 1'b0;
		res_status = ST_OK;
		idx_d      = byte_index_q;
		mok_d      = magic_ok_q;
		ver_d      = version_q;
		chk_d      = checksum_q;
		typ_d      = type_hash_q;
		fmt_d      = format_hash_q;
		tail_d     = tail_q;

		if (!finished_q) begin
			if (has_byte_s1) begin
				if (byte_index_q < IDX_VERSION) begin
					mok_d = magic_ok_q & (data_byte_s1 == HDR_MAGIC[byte_index_q[1:0]]);
					idx_d = byte_index_q + 1'b1;
					if (byte_index_q == IDX_VERSION - 1'b1 && !mok_d) begin
						res_status = ST_BAD_MAGIC;
						res_done   = 1'b1;
					end
				end else if (byte_index_q < IDX_CHECKSUM) begin
					ver_d = version_q | lane_word;
					idx_d = byte_index_q + 1'b1;
					if (byte_index_q == IDX_CHECKSUM - 1'b1) begin
						if (ver_d == '0 || ver_d > MAX_VERSION) begin
							res_status = ST_BAD_VERSION;
							res_done   = 1'b1;
						end else if (ver_d == VERSION_NO_CHECKSUM) begin
							// skip the checksum word
							idx_d = IDX_TYPE;
						end
					end
				end else if (byte_index_q < IDX_TYPE) begin
					chk_d = checksum_q | lane_word;
					idx_d = byte_index_q + 1'b1;
				end else if (byte_index_q < IDX_FORMAT) begin
					typ_d = type_hash_q | lane_word;
					idx_d = byte_index_q + 1'b1;
				end else if (byte_index_q < IDX_TAIL) begin
					fmt_d = format_hash_q | lane_word;
					idx_d = byte_index_q + 1'b1;
				end else if (byte_index_q <= IDX_LAST) begin
					tail_d = tail_q | lane_word;
					idx_d  = byte_index_q + 1'b1;
					if (byte_index_q == IDX_LAST) begin
						res_done = 1'b1;
						if (typ_d != exp_type_q) begin
							res_status = ST_TYPE_MISMATCH;
						end else if (tail_d[7:0] != exp_container_q) begin
							res_status = ST_CONTAINER_MISMATCH;
						end else if (tail_d[15:8] != exp_flags_q) begin
							res_status = ST_FLAGS_MISMATCH;
						end else if (fmt_d != exp_format_q) begin
							res_status = ST_FORMAT_MISMATCH;
						end else begin
							res_status = ST_OK;
						end
					end
				end
			end
			if (!res_done && eoi_s1) begin
				res_status = (idx_d < IDX_VERSION) ? ST_BAD_MAGIC : ST_TRUNCATED;
				res_done   = 1'b1;
			end
		end
	end

	// Next header state: restart on end of input, hold in skip after a result
	always_comb begin
		idx_n  = idx_d;
		fin_n  = finished_q | res_done;
		mok_n  = mok_d;
		ver_n  = ver_d;
		chk_n  = chk_d;
		typ_n  = typ_d;
		fmt_n  = fmt_d;
		tail_n = tail_d;
		if (eoi_s1 && (finished_q || res_done)) begin
			idx_n  = '0;
			fin_n  = 1'b0;
			mok_n  = 1'b1;
			ver_n  = '0;
			chk_n  = '0;
			typ_n  = '0;
			fmt_n  = '0;
			tail_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q  <= '0;
			finished_q    <= 1'b0;
			magic_ok_q    <= 1'b1;
			version_q     <= '0;
			checksum_q    <= '0;
			type_hash_q   <= '0;
			format_hash_q <= '0;
			tail_q        <= '0;
		end else if (s1_go) begin
			byte_index_q  <= idx_n;
			finished_q    <= fin_n;
			magic_ok_q    <= mok_n;
			version_q     <= ver_n;
			checksum_q    <= chk_n;
			type_hash_q   <= typ_n;
			format_hash_q <= fmt_n;
			tail_q        <= tail_n;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && res_done) begin
			out_valid_q <= 1'b1;
		end else if (hdr_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && res_done) begin
			res_status_q   <= res_status;
			res_version_q  <= ver_d;
			res_checksum_q <= chk_d;
			res_type_q     <= typ_d;
			res_format_q   <= fmt_d;
			res_tail_q     <= tail_d;
		end
	end

	assign hdr_out.valid          = out_valid_q;
	assign hdr_out.status         = res_status_q;
	assign hdr_out.version        = res_version_q;
	assign hdr_out.checksum       = res_checksum_q;
	assign hdr_out.type_hash      = res_type_q;
	assign hdr_out.format_hash    = res_format_q;
	assign hdr_out.container_code = res_tail_q[7:0];
	assign hdr_out.flag_bits      = res_tail_q[15:8];
	assign hdr_out.fixed_count    = res_tail_q[31:16];

	`BBHC_ASSERT_SAME(a_index_in_header, clk, arst_n, !finished_q,
		byte_index_q <= IDX_LAST, "byte index ran past the header while parsing")
	`BBHC_ASSERT_SAME(a_v1_no_checksum, clk, arst_n,
		!finished_q && byte_index_q >= IDX_TYPE && version_q == VERSION_NO_CHECKSUM,
		checksum_q == '0, "checksum captured for a version one header")
	`BBHC_ASSERT_SAME(a_skip_silent, clk, arst_n, s1_go && finished_q,
		!res_done, "result produced while skipping to end of input")
	`BBHC_ASSERT_NEXT(a_restart_after_end, clk, arst_n, s1_go && res_done && eoi_s1,
		byte_index_q == '0 && !finished_q && magic_ok_q,
		"header state not restarted after a result at end of input")

endmodule
